### rtl/fra_pkg.sv
package fra_pkg;

  localparam int Width = 32;
  localparam int MagW = 2 * Width;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StZeroDen = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  localparam logic ActReduce = 1'b0;
  localparam logic ActAdd = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMBINE,
    S_MOD,
    S_DIVN,
    S_DIVD,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       action;
    logic [31:0] first_numerator;
    logic [31:0] first_denominator;
    logic [31:0] second_numerator;
    logic [31:0] second_denominator;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_numerator;
    logic [31:0] result_denominator;
    logic [1:0]  status;
  } out_beat_t;

endpackage

### rtl/fra_in_if.sv
interface fra_in_if;
  logic valid;
  logic ready;
  fra_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fra_out_if.sv
interface fra_out_if;
  logic valid;
  logic ready;
  fra_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fraction_reduce_and_add.sv
// Fraction reduce/add. One beat at a time: in.ready is high only while idle.
// Reduce or add then reduce; GCD and both final divisions run on one shared
// 64-bit restoring divider, one quotient bit per cycle. Add first forms
// three 32x32 products, one per cycle. The GCD uses Euclid modulo steps;
// a zero denominator goes straight to output with status StZeroDen. The result
// register holds until out.ready; the next beat is taken after it leaves.
module fraction_reduce_and_add (
  input logic clk,
  input logic rst,
  fra_in_if.sink in,
  fra_out_if.source out
);

  localparam int W = fra_pkg::Width;
  localparam int M = fra_pkg::MagW;

  fra_pkg::state_t state, state_next;

  logic act;
  logic n1s, d1s, n2s, d2s, ns, ds;
  logic [W-1:0] n1m, d1m, n2m, d2m;
  logic [M-1:0] p1, p2, nm, dm, gb;
  logic [M-1:0] dvd, dvs, quo, rem;
  logic [6:0] cnt;
  fra_pkg::out_beat_t res;

  // shared multiplier operands
  logic [W-1:0] ma, mb;
  logic [M-1:0] prod;
  assign prod = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};

  // divider step
  logic [M:0] rtry;
  assign rtry = {rem, dvd[M-1]} - {1'b0, dvs};

  logic [M-1:0] rnext, qnext;
  assign rnext = rtry[M] ? {rem[M-2:0], dvd[M-1]} : rtry[M-1:0];
  assign qnext = {quo[M-2:0], ~rtry[M]};

  function automatic logic [W-1:0] mag_of(input logic [31:0] v);
    logic [W-1:0] x;
    x = v[W-1:0];
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [M-1:0] lim;
  assign lim = {{(M-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  function automatic logic [31:0] to_field(input logic neg, input logic [M-1:0] m);
    logic [31:0] v;
    v = m[31:0];
    return neg ? (~v + 32'd1) : v;
  endfunction

  always_comb begin
    ma = n1m;
    mb = d2m;
    case (state)
      fra_pkg::S_MUL2: begin
        ma = n2m;
        mb = d1m;
      end
      fra_pkg::S_MUL3: begin
        ma = d1m;
        mb = d2m;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      fra_pkg::S_IDLE: if (in.valid) state_next = fra_pkg::S_MUL1;
      fra_pkg::S_MUL1: begin
        if (d1m == '0 || (act == fra_pkg::ActAdd && d2m == '0)) state_next = fra_pkg::S_OUT;
        else if (act == fra_pkg::ActReduce) state_next = fra_pkg::S_COMBINE;
        else state_next = fra_pkg::S_MUL2;
      end
      fra_pkg::S_MUL2: state_next = fra_pkg::S_MUL3;
      fra_pkg::S_MUL3: state_next = fra_pkg::S_COMBINE;
      fra_pkg::S_COMBINE: state_next = fra_pkg::S_MOD;
      fra_pkg::S_MOD: begin
        if (cnt == 7'd0) state_next = fra_pkg::S_MOD;
      end
      fra_pkg::S_DIVN: ;
      fra_pkg::S_DIVD: ;
      fra_pkg::S_FINISH: state_next = fra_pkg::S_OUT;
      fra_pkg::S_OUT: if (out.ready) state_next = fra_pkg::S_IDLE;
      default: state_next = fra_pkg::S_IDLE;
    endcase
    if ((state == fra_pkg::S_MOD || state == fra_pkg::S_DIVN || state == fra_pkg::S_DIVD)
        && cnt == 7'(M)) begin
      case (state)
        fra_pkg::S_MOD: state_next = (rnext == '0) ? fra_pkg::S_DIVN : fra_pkg::S_MOD;
        fra_pkg::S_DIVN: state_next = fra_pkg::S_DIVD;
        fra_pkg::S_DIVD: state_next = fra_pkg::S_FINISH;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fra_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      fra_pkg::S_IDLE: begin
        act <= in.data.action;
        n1s <= in.data.first_numerator[W-1];
        d1s <= in.data.first_denominator[W-1];
        n2s <= in.data.second_numerator[W-1];
        d2s <= in.data.second_denominator[W-1];
        n1m <= mag_of(in.data.first_numerator);
        d1m <= mag_of(in.data.first_denominator);
        n2m <= mag_of(in.data.second_numerator);
        d2m <= mag_of(in.data.second_denominator);
      end
      fra_pkg::S_MUL1: begin
        p1 <= prod;
        res <= {32'd0, 32'd0, fra_pkg::StZeroDen};
      end
      fra_pkg::S_MUL2: p2 <= prod;
      fra_pkg::S_MUL3: dm <= prod;
      fra_pkg::S_COMBINE: begin
        if (act == fra_pkg::ActReduce) begin
          nm <= {{(M-W){1'b0}}, n1m};
          dm <= {{(M-W){1'b0}}, d1m};
          ns <= (n1m == '0) ? 1'b0 : n1s;
          ds <= d1s;
          gb <= {{(M-W){1'b0}}, d1m};
          dvd <= {{(M-W){1'b0}}, n1m};
          dvs <= {{(M-W){1'b0}}, d1m};
        end else begin
          ds <= d1s ^ d2s;
          gb <= dm;
          dvs <= dm;
          if ((n1s ^ d2s) == (n2s ^ d1s)) begin
            nm <= p1 + p2;
            dvd <= p1 + p2;
            ns <= (p1 + p2 == '0) ? 1'b0 : (n1s ^ d2s);
          end else if (p1 >= p2) begin
            nm <= p1 - p2;
            dvd <= p1 - p2;
            ns <= (p1 == p2) ? 1'b0 : (n1s ^ d2s);
          end else begin
            nm <= p2 - p1;
            dvd <= p2 - p1;
            ns <= n2s ^ d1s;
          end
        end
        rem <= '0;
        quo <= '0;
        cnt <= 7'd1;
      end
      fra_pkg::S_MOD, fra_pkg::S_DIVN, fra_pkg::S_DIVD: begin
        if (cnt == 7'(M)) begin
          cnt <= 7'd1;
          rem <= '0;
          quo <= '0;
          case (state)
            fra_pkg::S_MOD: begin
              if (rnext == '0) begin
                dvd <= nm;
                dvs <= gb;
              end else begin
                gb <= rnext;
                dvd <= gb;
                dvs <= rnext;
              end
            end
            fra_pkg::S_DIVN: begin
              nm <= qnext;
              dvd <= dm;
            end
            default: dm <= qnext;
          endcase
        end else begin
          cnt <= cnt + 7'd1;
          rem <= rnext;
          quo <= qnext;
          dvd <= {dvd[M-2:0], 1'b0};
        end
      end
      fra_pkg::S_FINISH: begin
        if ((ns ? nm > lim : nm >= lim) || (ds ? dm > lim : dm >= lim)) begin
          res <= {32'd0, 32'd0, fra_pkg::StOverflow};
        end else begin
          res <= {to_field(ns, nm), to_field(ds, dm), fra_pkg::StOk};
        end
      end
      default: ;
    endcase
  end

  assign in.ready = (state == fra_pkg::S_IDLE);
  assign out.valid = (state == fra_pkg::S_OUT);
  assign out.data = res;

endmodule
